/* hw/rtl/dpw_pkg.sv */
// Shared types, register codes and constants of the depth pixel to world point unit.
`timescale 1ns / 1ps

package dpw_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_W  = 3'd0,
		REG_QUAT_X  = 3'd1,
		REG_QUAT_Y  = 3'd2,
		REG_QUAT_Z  = 3'd3,
		REG_SHIFT_X = 3'd4,
		REG_SHIFT_Y = 3'd5,
		REG_SHIFT_Z = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic                  en;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// Signed Q2.30 matrix entry
	typedef logic signed [31:0] q30_t;
	localparam q30_t Q30_ONE = 32'sd1073741824;

	// Field widths
	localparam int PIX_W   = 12;
	localparam int DEPTH_W = 16;

	// Depth window in raw units
	localparam int DEPTH_MIN = 500;
	localparam int DEPTH_MAX = 25000;

	// Twice the principal point
	localparam int CX_TWICE = 639;
	localparam int CY_TWICE = 479;

	// x,y: round(a * 2^12 / 328125); z: round(raw * 2^13 / 625)
	localparam int DIV_XY = 328125;
	localparam int RND_XY = 164062;
	localparam int DIV_Z  = 625;
	localparam int RND_Z  = 312;

	// Datapath widths
	localparam int NUM_W  = 28;  // first divider numerator
	localparam int NUM2_W = 31;  // second divider numerator
	localparam int QA_W   = 10;  // coarse quotient of x,y
	localparam int Q2_W   = 13;  // fine quotient of x,y
	localparam int MAG_W  = 22;  // |x|,|y| in Q16.16
	localparam int Z_W    = 19;  // z in Q16.16
	localparam int P_W    = 23;  // signed camera-space coordinate

	typedef logic signed [P_W-1:0] pcoord_t;

	typedef struct packed {
		logic [PIX_W-1:0]   column;
		logic [PIX_W-1:0]   row;
		logic [DEPTH_W-1:0] depth_code;
		logic [7:0]         red_in;
		logic [7:0]         green_in;
		logic [7:0]         blue_in;
		logic [7:0]         class_in;
		logic [31:0]        certainty_in;
	} pixel_t;

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
		logic [7:0]         red_out;
		logic [7:0]         green_out;
		logic [7:0]         blue_out;
		logic [7:0]         class_out;
		logic [31:0]        certainty_out;
	} point_t;

endpackage

/* hw/rtl/dpw_stream_if.sv */
// Valid/ready stream interface carrying one request payload.
`timescale 1ns / 1ps

interface dpw_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/dpw_cdiv.sv */
// Pipelined unsigned division by a constant: reciprocal estimate, remainder, correction.
`timescale 1ns / 1ps

module dpw_cdiv #(
	parameter int NW  = 28,
	parameter int DIV = 625
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [NW-1:0]          n,
	output logic [NW-1:0]          q,
	output logic [$clog2(DIV)-1:0] r
);

	localparam longint unsigned RECIP_FULL = (64'd1 << 32) / DIV;
	localparam int RW = $clog2(RECIP_FULL + 1);
	localparam logic [RW-1:0] RECIP = RW'(RECIP_FULL);
	localparam int DW = $clog2(DIV);

	logic [NW+RW-1:0] est;
	logic [NW-1:0]    n_s1, q0_s1, q0_s2, q_s3;
	logic [DW:0]      r0_s2;
	logic [DW-1:0]    r_s3;

	// Estimate is the true quotient or one below it
	assign est = (NW+RW)'(n) * (NW+RW)'(RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1  <= n;
			q0_s1 <= NW'(est >> 32);
			q0_s2 <= q0_s1;
			r0_s2 <= (DW+1)'(n_s1 - NW'(q0_s1 * NW'(DIV)));
			// Fix up an estimate that fell one short
			if (r0_s2 >= (DW+1)'(DIV)) begin
				q_s3 <= q0_s2 + NW'(1);
				r_s3 <= DW'(r0_s2 - (DW+1)'(DIV));
			end else begin
				q_s3 <= q0_s2;
				r_s3 <= DW'(r0_s2);
			end
		end
	end

	assign q = q_s3;
	assign r = r_s3;

endmodule

/* hw/rtl/dpw_rot_build.sv */
// Quaternion registers and the sequencer that turns them into a Q2.30 rotation matrix.
`timescale 1ns / 1ps

module dpw_rot_build (
	input  logic             clk,
	input  logic             arst_n,
	input  dpw_pkg::cfg_wr_t wr,
	output logic             busy,
	output dpw_pkg::q30_t    rot [9]
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PROD  = 6'b000010,
		ST_DCHK  = 6'b000100,
		ST_DSET  = 6'b001000,
		ST_DSTEP = 6'b010000,
		ST_DEND  = 6'b100000
	} state_t;

	// Product slots
	localparam int P_WW = 0, P_XX = 1, P_YY = 2, P_ZZ = 3, P_XY = 4;
	localparam int P_XZ = 5, P_YZ = 6, P_WX = 7, P_WY = 8, P_WZ = 9;
	localparam logic [3:0] LAST_PROD  = 4'd9;
	localparam logic [3:0] LAST_ENTRY = 4'd8;
	localparam logic [4:0] LAST_STEP  = 5'd30;

	state_t             state_q;
	dpw_pkg::q30_t      quat_w_q, quat_x_q, quat_y_q, quat_z_q;
	dpw_pkg::q30_t      rot_q [9];
	logic [3:0]         k_q, e_q;
	logic [4:0]         step_q;
	logic signed [63:0] prod_q [10];
	logic [63:0]        d_q, rem_q;
	logic [31:0]        quo_q;
	logic               neg_q, sat_q;

	dpw_pkg::q30_t      op_a, op_b;
	logic signed [63:0] full, quarter, d_sum, num;
	logic [63:0]        mag, two_d, rem2;
	logic [32:0]        rounded;
	dpw_pkg::q30_t      entry;
	logic               quat_wr;

	assign quat_wr = wr.en && (wr.index == dpw_pkg::REG_QUAT_W || wr.index == dpw_pkg::REG_QUAT_X
		|| wr.index == dpw_pkg::REG_QUAT_Y || wr.index == dpw_pkg::REG_QUAT_Z);

	// Select the operand pair for the current product
	always_comb begin
		case (k_q)
			4'd0:    begin op_a = quat_w_q; op_b = quat_w_q; end
			4'd1:    begin op_a = quat_x_q; op_b = quat_x_q; end
			4'd2:    begin op_a = quat_y_q; op_b = quat_y_q; end
			4'd3:    begin op_a = quat_z_q; op_b = quat_z_q; end
			4'd4:    begin op_a = quat_x_q; op_b = quat_y_q; end
			4'd5:    begin op_a = quat_x_q; op_b = quat_z_q; end
			4'd6:    begin op_a = quat_y_q; op_b = quat_z_q; end
			4'd7:    begin op_a = quat_w_q; op_b = quat_x_q; end
			4'd8:    begin op_a = quat_w_q; op_b = quat_y_q; end
			default: begin op_a = quat_w_q; op_b = quat_z_q; end
		endcase
	end

	// Exact product, quartered toward zero
	assign full    = 64'(op_a) * 64'(op_b);
	assign quarter = (full + (full[63] ? 64'sd3 : 64'sd0)) >>> 2;

	assign d_sum = prod_q[P_WW] + prod_q[P_XX] + prod_q[P_YY] + prod_q[P_ZZ];

	// Numerator of the current matrix entry
	always_comb begin
		case (e_q)
			4'd0: num = prod_q[P_WW] + prod_q[P_XX] - prod_q[P_YY] - prod_q[P_ZZ];
			4'd1: num = (prod_q[P_XY] - prod_q[P_WZ]) <<< 1;
			4'd2: num = (prod_q[P_XZ] + prod_q[P_WY]) <<< 1;
			4'd3: num = (prod_q[P_XY] + prod_q[P_WZ]) <<< 1;
			4'd4: num = prod_q[P_WW] - prod_q[P_XX] + prod_q[P_YY] - prod_q[P_ZZ];
			4'd5: num = (prod_q[P_YZ] - prod_q[P_WX]) <<< 1;
			4'd6: num = (prod_q[P_XZ] - prod_q[P_WY]) <<< 1;
			4'd7: num = (prod_q[P_YZ] + prod_q[P_WX]) <<< 1;
			default: num = prod_q[P_WW] - prod_q[P_XX] - prod_q[P_YY] + prod_q[P_ZZ];
		endcase
	end

	assign mag   = num[63] ? 64'(-num) : 64'(num);
	assign two_d = {d_q[62:0], 1'b0};
	assign rem2  = {rem_q[62:0], 1'b0};

	// Round half away from zero and saturate
	assign rounded = ({1'b0, quo_q} + 33'd1) >> 1;
	always_comb begin
		if (neg_q) begin
			entry = (sat_q || rounded[31]) ? 32'sh80000000 : -$signed(rounded[31:0]);
		end else begin
			entry = (sat_q || rounded[31]) ? 32'sh7fffffff : $signed(rounded[31:0]);
		end
	end

	// Sequencer, quaternion registers and matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			quat_w_q <= dpw_pkg::Q30_ONE;
			quat_x_q <= '0;
			quat_y_q <= '0;
			quat_z_q <= '0;
			k_q      <= '0;
			e_q      <= '0;
			step_q   <= '0;
			for (int i = 0; i < 9; i++) begin
				rot_q[i] <= (i % 4 == 0) ? dpw_pkg::Q30_ONE : '0;
			end
		end else if (quat_wr) begin
			// Take the new component and restart the build
			unique case (wr.index)
				dpw_pkg::REG_QUAT_W: quat_w_q <= $signed(wr.data);
				dpw_pkg::REG_QUAT_X: quat_x_q <= $signed(wr.data);
				dpw_pkg::REG_QUAT_Y: quat_y_q <= $signed(wr.data);
				default:             quat_z_q <= $signed(wr.data);
			endcase
			state_q <= ST_PROD;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					state_q <= ST_IDLE;
				end
				ST_PROD: begin
					k_q <= k_q + 4'd1;
					if (k_q == LAST_PROD) begin
						state_q <= ST_DCHK;
					end
				end
				ST_DCHK: begin
					e_q <= '0;
					// Zero quaternion falls back to identity
					if (d_sum == 64'sd0) begin
						for (int i = 0; i < 9; i++) begin
							rot_q[i] <= (i % 4 == 0) ? dpw_pkg::Q30_ONE : '0;
						end
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DSET;
					end
				end
				ST_DSET: begin
					step_q  <= '0;
					state_q <= ST_DSTEP;
				end
				ST_DSTEP: begin
					step_q <= step_q + 5'd1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_DEND;
					end
				end
				ST_DEND: begin
					rot_q[e_q] <= entry;
					e_q        <= e_q + 4'd1;
					state_q    <= (e_q == LAST_ENTRY) ? ST_IDLE : ST_DSET;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Products and the restoring divider
	always_ff @(posedge clk) begin
		if (state_q == ST_PROD) begin
			prod_q[k_q] <= quarter;
		end
		if (state_q == ST_DCHK) begin
			d_q <= 64'(d_sum);
		end
		if (state_q == ST_DSET) begin
			neg_q <= num[63];
			sat_q <= mag >= two_d;
			if (mag >= d_q) begin
				quo_q <= 32'd1;
				rem_q <= mag - d_q;
			end else begin
				quo_q <= 32'd0;
				rem_q <= mag;
			end
		end
		if (state_q == ST_DSTEP) begin
			if (rem2 >= d_q) begin
				rem_q <= rem2 - d_q;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem2;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy = state_q != ST_IDLE;
	assign rot  = rot_q;

endmodule

/* hw/rtl/dpw_xform.sv */
// Rotate and translate a camera-space point, then round and saturate to Q16.16.
`timescale 1ns / 1ps

module dpw_xform (
	input  logic               clk,
	input  logic               en,
	input  dpw_pkg::q30_t      rot [9],
	input  logic signed [31:0] shift [3],
	input  dpw_pkg::pcoord_t   p [3],
	output logic signed [31:0] world [3]
);

	localparam int MW = 32 + dpw_pkg::P_W;
	localparam logic signed [63:0] HALF = 64'sd536870912;

	logic signed [MW-1:0] prod_s1 [9];
	logic signed [63:0]   sum_s2 [3];
	logic signed [31:0]   world_s3 [3];

	for (genvar i = 0; i < 9; i++) begin : g_mul
		// One multiplier per matrix entry
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1[i] <= MW'(rot[i]) * MW'(p[i % 3]);
			end
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		logic signed [33:0] fl;

		// Row sum with translation and rounding offset
		always_ff @(posedge clk) begin
			if (en) begin
				sum_s2[r] <= 64'(prod_s1[3*r]) + 64'(prod_s1[3*r+1]) + 64'(prod_s1[3*r+2])
					+ 64'($signed({shift[r], 30'b0})) + HALF;
			end
		end

		assign fl = sum_s2[r][63:30];

		// Floor to Q16.16 and saturate
		always_ff @(posedge clk) begin
			if (en) begin
				if (fl[33:31] == 3'b000 || fl[33:31] == 3'b111) begin
					world_s3[r] <= fl[31:0];
				end else begin
					world_s3[r] <= fl[33] ? 32'sh80000000 : 32'sh7fffffff;
				end
			end
		end

		assign world[r] = world_s3[r];
	end

endmodule

/* hw/rtl/depth_pixel_to_world_point_unit.sv */
// Top level: depth pixel back-projection and pose transform pipeline.
`timescale 1ns / 1ps

// Depth pixel to world point unit.
// Channel pixel (sink) takes one depth pixel per request: column, row, raw depth,
// color, class and confidence bits. Channel point (source) delivers one world point
// in signed Q16.16 meters with the attributes unchanged. Pixels off the stride grid
// or with raw depth outside 500..25000 produce no request on point.
// The configuration port writes the pose quaternion (registers 0-3) and the camera
// position (registers 4-6), one register per cycle while wr_en is high.
// A pixel request is taken every cycle unless a result is stalled on point or the
// matrix is being rebuilt. The twelve-stage pipeline holds the constant dividers,
// the nine matrix multipliers and the saturating row sums.
// A quaternion write rebuilds the rotation matrix in a serial divider, one quotient
// bit per cycle for each of nine entries; pixel.ready stays low while it runs.
// Reset loads the identity rotation and zero position and empties the pipeline.
// When point.ready is low with a result waiting, every stage holds and pixel.ready
// drops in the same cycle; nothing is lost or repeated.

module depth_pixel_to_world_point_unit #(
	parameter int STRIDE           = 4,
	parameter int PIXEL_INDEX_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [dpw_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [dpw_pkg::CFG_DATA_W-1:0]  wr_data,
	dpw_stream_if.sink                      pixel,
	dpw_stream_if.source                    point
);

	localparam int LAST     = 12;
	localparam int UB       = (PIXEL_INDEX_BITS < dpw_pkg::PIX_W) ? PIXEL_INDEX_BITS
		: dpw_pkg::PIX_W;
	localparam logic [dpw_pkg::PIX_W-1:0] UMASK = dpw_pkg::PIX_W'((64'd1 << UB) - 1);
	localparam int SR_SHIFT = 13;
	localparam int SR_R     = (1 << SR_SHIFT) / STRIDE;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  label;
		logic [31:0] certainty;
		logic        neg_x;
		logic        neg_y;
	} meta_t;

	typedef struct packed {
		logic [dpw_pkg::QA_W-1:0] qa_x;
		logic [dpw_pkg::QA_W-1:0] qa_y;
		logic [dpw_pkg::Z_W-1:0]  z;
	} hold_t;

	// Pipeline registers; array index is the stage number
	logic [LAST:1]    valid_s;
	meta_t            meta_s [2:LAST];
	hold_t            hold_in;
	hold_t            hold_s [6:8];
	dpw_pkg::pixel_t  pix_s1;
	logic [dpw_pkg::NUM_W-1:0] ax_s2, ay_s2, nz_s2;
	dpw_pkg::pcoord_t p_s9 [3];

	logic signed [31:0] shift_x_q, shift_y_q, shift_z_q;
	logic signed [31:0] shift_v [3];

	dpw_pkg::cfg_wr_t wr;
	dpw_pkg::q30_t    rot [9];
	logic             busy, en, keep;

	logic [dpw_pkg::PIX_W-1:0]    u, v;
	logic signed [13:0]           dx, dy;
	logic [12:0]                  adx, ady;
	logic [28:0]                  ax_full, ay_full, nz_full;

	logic [dpw_pkg::NUM_W-1:0]      qa_x, qa_y, z_q;
	logic [$clog2(dpw_pkg::DIV_XY)-1:0] ra_x, ra_y;
	logic [$clog2(dpw_pkg::DIV_Z)-1:0]  rz;
	logic [dpw_pkg::NUM2_W-1:0]     n2_x, n2_y, q2_x, q2_y;
	logic [$clog2(dpw_pkg::DIV_XY)-1:0] r2_x, r2_y;
	logic [dpw_pkg::MAG_W-1:0]      mag_x, mag_y;
	logic signed [31:0]             world [3];

	// Remainder test against the stride by reciprocal multiplication
	function automatic logic stride_hit(input logic [dpw_pkg::PIX_W-1:0] val);
		logic [25:0]               est;
		logic [dpw_pkg::PIX_W-1:0] q0, r0;
		est = 26'(val) * 26'(SR_R);
		q0  = dpw_pkg::PIX_W'(est >> SR_SHIFT);
		r0  = val - dpw_pkg::PIX_W'(q0 * dpw_pkg::PIX_W'(STRIDE));
		return (r0 == '0) || (r0 == dpw_pkg::PIX_W'(STRIDE));
	endfunction

	// Whole pipeline advances unless a finished result is held
	assign en          = !valid_s[LAST] || point.ready;
	assign pixel.ready = en && !busy;

	// Configuration
	assign wr = '{en: wr_en, index: wr_index, data: wr_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_x_q <= '0;
			shift_y_q <= '0;
			shift_z_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				dpw_pkg::REG_SHIFT_X: shift_x_q <= $signed(wr_data);
				dpw_pkg::REG_SHIFT_Y: shift_y_q <= $signed(wr_data);
				dpw_pkg::REG_SHIFT_Z: shift_z_q <= $signed(wr_data);
				default: ;
			endcase
		end
	end

	assign shift_v[0] = shift_x_q;
	assign shift_v[1] = shift_y_q;
	assign shift_v[2] = shift_z_q;

	dpw_rot_build u_rot (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.busy   (busy),
		.rot    (rot)
	);

	// Valid bits; dropped pixels leave the pipeline after stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s[1] <= pixel.valid && !busy;
			valid_s[2] <= valid_s[1] && keep;
			valid_s[LAST:3] <= valid_s[LAST-1:2];
		end
	end

	// Stage 1: capture the request
	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= pixel.data;
		end
	end

	// Stage 2: filter and form the numerators
	assign u    = pix_s1.column & UMASK;
	assign v    = pix_s1.row & UMASK;
	assign keep = stride_hit(u) && stride_hit(v)
		&& pix_s1.depth_code >= dpw_pkg::DEPTH_W'(dpw_pkg::DEPTH_MIN)
		&& pix_s1.depth_code <= dpw_pkg::DEPTH_W'(dpw_pkg::DEPTH_MAX);

	assign dx  = $signed({1'b0, u, 1'b0}) - 14'(dpw_pkg::CX_TWICE);
	assign dy  = $signed({1'b0, v, 1'b0}) - 14'(dpw_pkg::CY_TWICE);
	assign adx = dx[13] ? 13'(-dx) : 13'(dx);
	assign ady = dy[13] ? 13'(-dy) : 13'(dy);
	assign ax_full = 29'(adx) * 29'(pix_s1.depth_code);
	assign ay_full = 29'(ady) * 29'(pix_s1.depth_code);
	assign nz_full = {pix_s1.depth_code, 13'b0} + 29'(dpw_pkg::RND_Z);

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2 <= ax_full[dpw_pkg::NUM_W-1:0];
			ay_s2 <= ay_full[dpw_pkg::NUM_W-1:0];
			nz_s2 <= nz_full[dpw_pkg::NUM_W-1:0];
			meta_s[2] <= '{red: pix_s1.red_in, green: pix_s1.green_in,
				blue: pix_s1.blue_in, label: pix_s1.class_in,
				certainty: pix_s1.certainty_in, neg_x: dx[13], neg_y: dy[13]};
			for (int i = 3; i <= LAST; i++) begin
				meta_s[i] <= meta_s[i-1];
			end
		end
	end

	// Stages 3-5: coarse division of x,y and full division of z
	dpw_cdiv #(.NW(dpw_pkg::NUM_W), .DIV(dpw_pkg::DIV_XY)) u_div_ax (
		.clk (clk), .en (en), .n (ax_s2), .q (qa_x), .r (ra_x)
	);
	dpw_cdiv #(.NW(dpw_pkg::NUM_W), .DIV(dpw_pkg::DIV_XY)) u_div_ay (
		.clk (clk), .en (en), .n (ay_s2), .q (qa_y), .r (ra_y)
	);
	dpw_cdiv #(.NW(dpw_pkg::NUM_W), .DIV(dpw_pkg::DIV_Z)) u_div_z (
		.clk (clk), .en (en), .n (nz_s2), .q (z_q), .r (rz)
	);

	// Stages 6-8: remainder scaled by 2^12 with half added, then divided again
	assign n2_x = dpw_pkg::NUM2_W'({ra_x, 12'b0}) + dpw_pkg::NUM2_W'(dpw_pkg::RND_XY);
	assign n2_y = dpw_pkg::NUM2_W'({ra_y, 12'b0}) + dpw_pkg::NUM2_W'(dpw_pkg::RND_XY);

	dpw_cdiv #(.NW(dpw_pkg::NUM2_W), .DIV(dpw_pkg::DIV_XY)) u_div_fx (
		.clk (clk), .en (en), .n (n2_x), .q (q2_x), .r (r2_x)
	);
	dpw_cdiv #(.NW(dpw_pkg::NUM2_W), .DIV(dpw_pkg::DIV_XY)) u_div_fy (
		.clk (clk), .en (en), .n (n2_y), .q (q2_y), .r (r2_y)
	);

	// Hold the coarse quotients and z alongside the second division
	assign hold_in = '{qa_x: qa_x[dpw_pkg::QA_W-1:0], qa_y: qa_y[dpw_pkg::QA_W-1:0],
		z: z_q[dpw_pkg::Z_W-1:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			hold_s[6] <= hold_in;
			for (int i = 7; i <= 8; i++) begin
				hold_s[i] <= hold_s[i-1];
			end
		end
	end

	// Stage 9: assemble signed camera-space point
	assign mag_x = dpw_pkg::MAG_W'({hold_s[8].qa_x, 12'b0})
		+ dpw_pkg::MAG_W'(q2_x[dpw_pkg::Q2_W-1:0]);
	assign mag_y = dpw_pkg::MAG_W'({hold_s[8].qa_y, 12'b0})
		+ dpw_pkg::MAG_W'(q2_y[dpw_pkg::Q2_W-1:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s9[0] <= meta_s[8].neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
			p_s9[1] <= meta_s[8].neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
			p_s9[2] <= dpw_pkg::P_W'($signed({1'b0, hold_s[8].z}));
		end
	end

	// Stages 10-12: rotate, translate, round
	dpw_xform u_xform (
		.clk   (clk),
		.en    (en),
		.rot   (rot),
		.shift (shift_v),
		.p     (p_s9),
		.world (world)
	);

	assign point.valid = valid_s[LAST];
	assign point.data  = '{world_x: world[0], world_y: world[1], world_z: world[2],
		red_out: meta_s[LAST].red, green_out: meta_s[LAST].green,
		blue_out: meta_s[LAST].blue, class_out: meta_s[LAST].label,
		certainty_out: meta_s[LAST].certainty};

endmodule

/* hw/rtl/dpw_checker.sv */
// Port-level checks of the depth pixel to world point unit, bound to its top level.
`timescale 1ns / 1ps

module dpw_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pixel_ready,
	input logic                          point_valid,
	input logic                          point_ready,
	input dpw_pkg::point_t               point_data,
	input logic                          wr_en,
	input logic [dpw_pkg::CFG_IDX_W-1:0] wr_index
);

	// Hold a stalled result
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_ready |=> point_valid)
		else $error("stalled point request dropped");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_ready |=> $stable(point_data))
		else $error("stalled point payload changed");

	// A quaternion write blocks new pixels while the matrix is rebuilt
	a_rebuild_block: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && (wr_index == dpw_pkg::REG_QUAT_W || wr_index == dpw_pkg::REG_QUAT_X
			|| wr_index == dpw_pkg::REG_QUAT_Y || wr_index == dpw_pkg::REG_QUAT_Z)
		|=> !pixel_ready)
		else $error("pixel accepted during matrix rebuild");

	// Reset empties the pipeline
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !point_valid)
		else $error("point request during reset");

endmodule

bind depth_pixel_to_world_point_unit dpw_checker u_dpw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_ready (pixel.ready),
	.point_valid (point.valid),
	.point_ready (point.ready),
	.point_data  (point.data),
	.wr_en       (wr_en),
	.wr_index    (wr_index)
);
